@@ design/edr_pkg.sv @@
// Shared types, constants and the arctangent table of the odometry block.
`timescale 1ns / 1ps
package edr_pkg;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] sample_value;
    logic [15:0]        elapsed_us;
  } edr_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] linear_speed;
    logic signed [31:0] yaw_rate;
  } edr_out_t;

  // One tick job handed from the front to the back.
  typedef struct packed {
    logic signed [31:0] rate;
    logic signed [31:0] dcount;
    logic [15:0]        dt;
  } edr_job_t;

  localparam logic [1:0] CMD_ENCODER  = 2'd0;
  localparam logic [1:0] CMD_GYRO     = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [31:0] MPC_RESET      = 32'd36370;
  localparam logic [33:0] CORDIC_GAIN    = 34'd652032874;
  localparam logic [25:0] HEADING_K      = 26'd44798134;
  localparam logic [19:0] SPEED_SCALE    = 20'd1000000;
  localparam logic [11:0] SPEED_QMAX     = 12'd2148;
  localparam int          ATAN_LEN       = 24;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:    r = 30'h20000000;
      5'd1:    r = 30'h12E4051E;
      5'd2:    r = 30'h09FB385B;
      5'd3:    r = 30'h051111D4;
      5'd4:    r = 30'h028B0D43;
      5'd5:    r = 30'h0145D7E1;
      5'd6:    r = 30'h00A2F61E;
      5'd7:    r = 30'h00517C55;
      5'd8:    r = 30'h0028BE53;
      5'd9:    r = 30'h00145F2F;
      5'd10:   r = 30'h000A2F98;
      5'd11:   r = 30'h000517CC;
      5'd12:   r = 30'h00028BE6;
      5'd13:   r = 30'h000145F3;
      5'd14:   r = 30'h0000A2FA;
      5'd15:   r = 30'h0000517D;
      5'd16:   r = 30'h000028BE;
      5'd17:   r = 30'h0000145F;
      5'd18:   r = 30'h00000A30;
      5'd19:   r = 30'h00000518;
      5'd20:   r = 30'h0000028C;
      5'd21:   r = 30'h00000146;
      5'd22:   r = 30'h000000A3;
      5'd23:   r = 30'h00000051;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

@@ design/edr_front.sv @@
// Front end: accepts items, keeps sensor state and the register, queues ticks.
`timescale 1ns / 1ps
module edr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  edr_pkg::edr_in_t item_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [31:0]      cfg_data_i,
  output logic [31:0]      mpc_o,
  output logic             job_push_o,
  output edr_pkg::edr_job_t job_o,
  input  logic             job_full_i
);
  import edr_pkg::*;

  logic        seen_q, seen_d;
  logic [31:0] offset_q, offset_d, now_q, now_d, before_q, before_d;
  logic [31:0] gyro_q, gyro_d, mpc_q;
  logic        accept;

  assign full        = job_full_i;
  assign accept      = push && !job_full_i;
  assign cfg_ready_o = 1'b1;
  assign mpc_o       = mpc_q;

  always_comb begin
    seen_d     = seen_q;
    offset_d   = offset_q;
    now_d      = now_q;
    before_d   = before_q;
    gyro_d     = gyro_q;
    job_push_o = 1'b0;
    job_o.rate   = gyro_q;
    job_o.dcount = now_q - before_q;
    job_o.dt     = item_i.elapsed_us;
    if (accept) begin
      unique case (item_i.command)
        CMD_ENCODER: begin
          if (!seen_q) begin
            offset_d = item_i.sample_value;
            now_d    = '0;
            before_d = '0;
            seen_d   = 1'b1;
          end else begin
            now_d = item_i.sample_value - offset_q;
          end
        end
        CMD_GYRO: gyro_d = item_i.sample_value;
        CMD_TICK: begin
          before_d   = now_q;
          job_push_o = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      offset_q <= '0;
      now_q    <= '0;
      before_q <= '0;
      gyro_q   <= '0;
      mpc_q    <= MPC_RESET;
    end else begin
      seen_q   <= seen_d;
      offset_q <= offset_d;
      now_q    <= now_d;
      before_q <= before_d;
      gyro_q   <= gyro_d;
      if (cfg_valid_i) begin
        mpc_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ design/edr_fifo.sv @@
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module edr_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  edr_pkg::edr_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output edr_pkg::edr_job_t data_o,
  output logic              valid_o
);
  import edr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  edr_job_t        mem_q [DEPTH];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ design/edr_back.sv @@
// Back end: heading integration, CORDIC, position update, speed division.
`timescale 1ns / 1ps
module edr_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  edr_pkg::edr_job_t job_i,
  output logic              job_pop_o,
  input  logic [31:0]       mpc_i,
  output logic              out_valid_o,
  output edr_pkg::edr_out_t out_o,
  input  logic              out_pop_i
);
  import edr_pkg::*;

  localparam int NST = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  typedef enum logic [3:0] {
    S_IDLE, S_HMAG, S_HKA, S_HKB, S_HADD, S_DMAG, S_CSTART, S_CITER, S_CDONE,
    S_MMUL, S_MADD, S_SMUL, S_SDIV, S_SFIN, S_EMIT
  } state_e;

  state_e             state_q;
  edr_job_t           job_q;
  logic [47:0]        mag_q;
  logic [49:0]        prod_a_q, prod_b_q;
  logic [31:0]        heading_q;
  logic [63:0]        dmag_q;
  logic signed [33:0] cx_q, cy_q, cz_q, cos_q, sin_q;
  logic [4:0]         iter_q;
  logic               flip_q, pass_q, axis_q, neg_q;
  logic [15:0]        qz_q, qw_q;
  logic [47:0]        xacc_q, yacc_q, mul_hi_q;
  logic [66:0]        mul_lo_q;
  logic [63:0]        num_q;
  logic [31:0]        rem_q, quo_q, speed_q;
  logic               out_valid_q;
  edr_out_t           out_q;

  // Combinational helpers
  logic               rneg, dneg;
  logic [31:0]        rabs, dabs, step32, den, cang, cang2;
  logic               cflip;
  logic signed [33:0] nx, ny, nz, atan_s, fx, fy, trig;
  logic [33:0]        tmag;
  logic [47:0]        pmove, pacc;
  logic [43:0]        den_lim;
  logic [32:0]        shifted, lim;
  logic [31:0]        smag;

  function automatic logic [15:0] quat_q14(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [18:0] r;
    t = 35'(v) + 35'sd32768;
    r = 19'(t >>> 16);
    if (r > 19'sd16384) begin
      r = 19'sd16384;
    end else if (r < -19'sd16384) begin
      r = -19'sd16384;
    end
    return r[15:0];
  endfunction

  assign rneg   = job_q.rate[31];
  assign rabs   = rneg ? 32'd0 - job_q.rate : job_q.rate;
  assign dneg   = job_q.dcount[31];
  assign dabs   = dneg ? 32'd0 - job_q.dcount : job_q.dcount;
  assign step32 = 32'((prod_a_q + 50'd128 + (prod_b_q >> 24)) >> 8);
  assign den    = {job_q.dt, 16'd0};
  assign den_lim = 44'(den) * 44'(SPEED_QMAX);

  // Angle for this CORDIC pass: heading or its arithmetic half
  assign cang  = pass_q ? {heading_q[31], heading_q[31:1]} : heading_q;
  assign cflip = cang[31] ^ cang[30];
  assign cang2 = cflip ? cang + 32'h80000000 : cang;

  assign atan_s = 34'(atan_turn(iter_q));
  always_comb begin
    if (!cz_q[33]) begin
      nx = cx_q - (cy_q >>> iter_q);
      ny = cy_q + (cx_q >>> iter_q);
      nz = cz_q - atan_s;
    end else begin
      nx = cx_q + (cy_q >>> iter_q);
      ny = cy_q - (cx_q >>> iter_q);
      nz = cz_q + atan_s;
    end
  end
  assign fx = flip_q ? -cx_q : cx_q;
  assign fy = flip_q ? -cy_q : cy_q;

  assign trig  = axis_q ? sin_q : cos_q;
  assign tmag  = trig[33] ? 34'd0 - trig : trig;
  assign pmove = (mul_hi_q << 2) + 48'((mul_lo_q + 67'd536870912) >> 30);
  assign pacc  = (axis_q ? yacc_q : xacc_q) + (neg_q ? 48'd0 - pmove : pmove);

  // Bring the next lower dividend bit into the partial remainder
  assign shifted = {rem_q, num_q[31]};
  assign lim     = dneg ? 33'h080000000 : 33'h07FFFFFFF;
  assign smag    = (33'(quo_q) > lim) ? lim[31:0] : quo_q;

  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE:   if (job_valid_i) job_q <= job_i;
      S_HMAG:   mag_q <= rabs * job_q.dt;
      S_HKA:    prod_a_q <= mag_q[47:24] * HEADING_K;
      S_HKB:    prod_b_q <= mag_q[23:0] * HEADING_K;
      S_DMAG:   dmag_q <= dabs * mpc_i;
      S_CSTART: begin
        flip_q <= cflip;
        cx_q   <= CORDIC_GAIN;
        cy_q   <= '0;
        cz_q   <= 34'(signed'(cang2));
      end
      S_CITER: begin
        cx_q <= nx;
        cy_q <= ny;
        cz_q <= nz;
      end
      S_CDONE: begin
        if (!pass_q) begin
          cos_q <= fx;
          sin_q <= fy;
        end else begin
          qz_q <= quat_q14(fy);
          qw_q <= quat_q14(fx);
        end
      end
      S_MMUL: begin
        neg_q    <= dneg ^ trig[33];
        mul_hi_q <= 48'(dmag_q[63:32] * tmag);
        mul_lo_q <= 67'(dmag_q[31:0] * tmag);
      end
      S_SMUL: begin
        num_q <= dmag_q[43:0] * SPEED_SCALE + 64'(den >> 1);
        quo_q <= '0;
        if (job_q.dt == '0) begin
          speed_q <= '0;
        end else if (dmag_q >= 64'(den_lim)) begin
          speed_q <= dneg ? 32'h80000000 : 32'h7FFFFFFF;
        end
      end
      S_SDIV: begin
        num_q <= num_q << 1;
        if (shifted >= 33'(den)) begin
          rem_q <= 32'(shifted - 33'(den));
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= shifted[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      S_SFIN:   speed_q <= dneg ? 32'd0 - smag : smag;
      S_EMIT: begin
        if (!out_valid_q || out_pop_i) begin
          out_q.pos_x        <= xacc_q[47:16];
          out_q.pos_y        <= yacc_q[47:16];
          out_q.heading      <= heading_q[31:16];
          out_q.quat_z       <= qz_q;
          out_q.quat_w       <= qw_q;
          out_q.linear_speed <= speed_q;
          out_q.yaw_rate     <= (job_q.dt != '0) ? job_q.rate : '0;
        end
      end
      default: ;
    endcase
    // Seed the divider remainder with the upper dividend word
    if (state_q == S_SMUL) begin
      rem_q <= 32'((dmag_q[43:0] * SPEED_SCALE + 64'(den >> 1)) >> 32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      pass_q      <= 1'b0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
      heading_q   <= '0;
      xacc_q      <= '0;
      yacc_q      <= '0;
    end else begin
      if ((state_q == S_EMIT) && (!out_valid_q || out_pop_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:   if (job_valid_i) state_q <= S_HMAG;
        S_HMAG:   state_q <= S_HKA;
        S_HKA:    state_q <= S_HKB;
        S_HKB:    state_q <= S_HADD;
        S_HADD: begin
          heading_q <= heading_q + (rneg ? 32'd0 - step32 : step32);
          state_q   <= S_DMAG;
        end
        S_DMAG: begin
          pass_q  <= 1'b0;
          state_q <= S_CSTART;
        end
        S_CSTART: begin
          iter_q  <= '0;
          state_q <= S_CITER;
        end
        S_CITER: begin
          iter_q <= iter_q + 1'b1;
          if (iter_q == 5'(NST - 1)) state_q <= S_CDONE;
        end
        S_CDONE: begin
          if (!pass_q) begin
            pass_q  <= 1'b1;
            state_q <= S_CSTART;
          end else begin
            axis_q  <= 1'b0;
            state_q <= S_MMUL;
          end
        end
        S_MMUL:   state_q <= S_MADD;
        S_MADD: begin
          if (axis_q) yacc_q <= pacc;
          else        xacc_q <= pacc;
          axis_q  <= 1'b1;
          state_q <= axis_q ? S_SMUL : S_MMUL;
        end
        S_SMUL: begin
          iter_q <= '0;
          if (job_q.dt == '0 || dmag_q >= 64'(den_lim)) state_q <= S_EMIT;
          else                                          state_q <= S_SDIV;
        end
        S_SDIV: begin
          iter_q <= iter_q + 1'b1;
          if (iter_q == 5'd31) state_q <= S_SFIN;
        end
        S_SFIN:   state_q <= S_EMIT;
        S_EMIT: begin
          if (!out_valid_q || out_pop_i) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/encoder_gyro_dead_reckoning.sv @@
// Top level of the encoder and gyro dead-reckoning odometry block.
`timescale 1ns / 1ps
// Encoder (command 0) and gyro (command 1) items are absorbed by the front end
// and produce no result; the first encoder item sets the zero offset. Each
// tick (command 2) snapshots the gyro rate and the count change into a short
// job queue and yields exactly one result, in order. The back end works one
// tick at a time: it takes the job, runs the heading multiply-accumulate and
// the travel product, then the heading and half-heading CORDIC passes on one
// shared rotator, the two position updates, the speed setup and the
// bit-serial speed divider (skipped when elapsed is zero or the speed
// saturates), and finally loads the result register. Sensor items keep
// flowing while a tick is computed; push stalls (full high) only when the
// job queue holds QUEUE_DEPTH ticks. The result register frees the back end
// as soon as the previous result is popped. Heading wraps at a full turn;
// positions wrap modulo 2^48 in 2^-32 m inside. The metres_per_count
// register is written through the cfg channel, which is always ready.
module encoder_gyro_dead_reckoning #(
  parameter int CORDIC_STAGES = 16,
  parameter int QUEUE_DEPTH   = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  edr_pkg::edr_in_t  item_i,
  output logic              empty,
  input  logic              pop,
  output edr_pkg::edr_out_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);
  import edr_pkg::*;

  logic     job_push, job_full, job_valid, job_pop, out_valid;
  logic [31:0] mpc;
  edr_job_t job_in, job_out;

  // Classify items, hold sensor state, emit tick jobs
  edr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .mpc_o       (mpc),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  // Decouple the front from the long back-end computation
  edr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .valid_o (job_valid)
  );

  // Integrate, rotate, divide and register the result
  edr_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .mpc_i       (mpc),
    .out_valid_o (out_valid),
    .out_o       (result_o),
    .out_pop_i   (pop)
  );

  assign empty = !out_valid;

endmodule

@@ design/edr_checker.sv @@
// Port-level checker for the odometry block, bound to the top level.
`timescale 1ns / 1ps
module edr_checker #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input edr_pkg::edr_in_t  item_i,
  input logic              empty,
  input logic              pop,
  input edr_pkg::edr_out_t result_o
);
  import edr_pkg::*;

  logic [7:0] pending_q;
  logic       tick_in, res_out;

  assign tick_in = push && !full && (item_i.command == CMD_TICK);
  assign res_out = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(tick_in) - 8'(res_out);
    end
  end

  // A waiting result holds until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while waiting");

  // Every result belongs to an accepted tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != 8'd0))
    else $error("result without tick");

  // Queue, back end and result register bound the outstanding ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 8'(QUEUE_DEPTH + 2))
    else $error("too many ticks outstanding");

  // With no tick outstanding the block does not stall pushes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 8'd0) |-> !full)
    else $error("full with nothing outstanding");

endmodule

bind encoder_gyro_dead_reckoning edr_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_edr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .item_i   (item_i),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
